// ===== sv/ritoa_pkg.sv =====
// ----------------------------------------------------------------------------
// ritoa_pkg: shared constants and types for the radix integer to ASCII unit
// Field widths, character codes, radix limits and the sequencer state type.
// ----------------------------------------------------------------------------
package ritoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_CHARS   = 33;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W      = $clog2(MAX_CHARS);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DIGIT_TEN = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;  // '7', so '7' + 10 = 'A'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_OUT
  } state_t;

endpackage

// ===== sv/radix_integer_to_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_unit: integer to ASCII text in radix 2..36
// Sequence: one divider pass per digit, then the sign when negative, then each
// character is fetched from the store and held until the sink takes it.
// Throughput: one item at a time, set by the bit-serial divider loop.
// Reset: synchronous, active high; clears the sequencer and handshake state.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [ritoa_pkg::RADIX_W-1:0]     radix,
  input  logic [ritoa_pkg::VALUE_WIDTH-1:0] value,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ritoa_pkg::CHAR_W-1:0]      char_out,
  output logic                              last
);
  import ritoa_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]   digit_count, digit_count_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic               negative_flag, negative_flag_next;
  logic [RADIX_W-1:0] base, base_next;

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [RADIX_W-1:0]     base_in;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RADIX_W-1:0]     div_remainder;
  logic                   div_done;

  logic [CHAR_W-1:0] digit_char;
  logic              wr_en;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [CHAR_W-1:0] rd_data;

  // Handshake: take a new item only while idle; the result sits in S_OUT.
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign out_xfer  = out_valid && !out_stall;
  assign char_out  = rd_data;
  assign last      = (rd_idx == '0);

  // Clamp the radix into 2..36 and take the magnitude of a negative word.
  // The signed minimum negates to itself, which is its unsigned magnitude.
  always_comb begin
    if (radix < RADIX_MIN) begin
      base_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_in = RADIX_MAX;
    end else begin
      base_in = radix;
    end
  end

  assign neg_in    = mode && value[VALUE_WIDTH-1];
  assign magnitude = neg_in ? (~value + VALUE_WIDTH'(1)) : value;

  // Digit value to character: 0..9 from '0', ten and up from 'A'.
  assign digit_char = (div_remainder < DIGIT_TEN)
                    ? CHAR_ZERO + CHAR_W'(div_remainder)
                    : CHAR_SEVEN + CHAR_W'(div_remainder);

  // First division takes the input magnitude; later ones take the quotient back.
  assign div_dividend = (state == S_IDLE) ? magnitude : div_quotient;

  ritoa_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .done      (div_done)
  );

  // Characters go in least significant first and come out from the top down.
  ritoa_char_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (digit_count[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      digit_count   <= '0;
      rd_idx        <= '0;
      negative_flag <= 1'b0;
    end else begin
      state         <= state_next;
      digit_count   <= digit_count_next;
      rd_idx        <= rd_idx_next;
      negative_flag <= negative_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
  end

  always_comb begin
    state_next         = state;
    digit_count_next   = digit_count;
    rd_idx_next        = rd_idx;
    negative_flag_next = negative_flag;
    base_next          = base;
    div_start          = 1'b0;
    wr_en              = 1'b0;
    wr_data            = digit_char;
    rd_en              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          // Latch the clamped radix and sign, start the first digit.
          base_next          = base_in;
          negative_flag_next = neg_in;
          digit_count_next   = '0;
          div_start          = 1'b1;
          state_next         = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          wr_en            = 1'b1;
          digit_count_next = digit_count + CNT_W'(1);
          if (div_quotient != '0) begin
            // More digits: divide the quotient again right away.
            div_start = 1'b1;
          end else if (negative_flag) begin
            state_next = S_SIGN;
          end else begin
            rd_idx_next = digit_count;
            state_next  = S_RD;
          end
        end
      end
      S_SIGN: begin
        // Append the minus sign; it comes out first.
        wr_en            = 1'b1;
        wr_data          = CHAR_MINUS;
        digit_count_next = digit_count + CNT_W'(1);
        rd_idx_next      = digit_count;
        state_next       = S_RD;
      end
      S_RD: begin
        // Fetch the next character; read data is valid next cycle.
        rd_en      = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Hold the character until the transfer completes.
        if (out_xfer) begin
          if (last) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx - CNT_W'(1);
            state_next  = S_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ritoa_divider.sv =====
// ----------------------------------------------------------------------------
// ritoa_divider: bit-serial restoring divider by a small radix
// Shifts one dividend bit per cycle into a narrow remainder; VALUE_WIDTH steps.
// ----------------------------------------------------------------------------
module ritoa_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ritoa_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [ritoa_pkg::RADIX_W-1:0]   divisor,
  output logic [ritoa_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [ritoa_pkg::RADIX_W-1:0]   remainder,
  output logic                            done
);
  import ritoa_pkg::*;

  logic               running;
  logic [BIT_W-1:0]   bit_cnt;
  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   trial_sub;
  logic               fits;

  // Trial subtract of the divisor from the remainder with the next bit in.
  assign trial     = {remainder, quotient[VALUE_WIDTH-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && bit_cnt == BIT_W'(VALUE_WIDTH - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      bit_cnt   <= '0;
    end else if (running) begin
      quotient  <= {quotient[VALUE_WIDTH-2:0], fits};
      remainder <= fits ? trial_sub[RADIX_W-1:0] : trial[RADIX_W-1:0];
      bit_cnt   <= bit_cnt + BIT_W'(1);
    end
  end

endmodule

// ===== sv/ritoa_char_store.sv =====
// ----------------------------------------------------------------------------
// ritoa_char_store: character buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ritoa_char_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ritoa_pkg::ADDR_W-1:0] wr_addr,
  input  logic [ritoa_pkg::CHAR_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ritoa_pkg::ADDR_W-1:0] rd_addr,
  output logic [ritoa_pkg::CHAR_W-1:0] rd_data
);
  import ritoa_pkg::*;

  logic [CHAR_W-1:0] mem [MAX_CHARS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
